/* rtl/hich_pkg.sv */
// ---------------------------------------------------------------------------
// hich_pkg
// Shared types, CORDIC arctangent table and microcode ROM for the
// hard-iron calibrated heading unit.
// ---------------------------------------------------------------------------
package hich_pkg;

  localparam int DIFF_W     = 17;
  localparam int GUARD_BITS = 20;
  localparam int VEC_W      = DIFF_W + GUARD_BITS + 3;
  localparam int TABLE_FRAC = 24;
  localparam int TABLE_LEN  = 24;
  localparam int WHOLE_W    = 11;
  localparam int PC_W       = 4;

  localparam logic [1:0] REQ_HEADING = 2'd0;
  localparam logic [1:0] REQ_SEED    = 2'd1;
  localparam logic [1:0] REQ_TRACK   = 2'd2;
  localparam logic [1:0] REQ_FINISH  = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SEED,
    OP_TRACK,
    OP_FINISH,
    OP_LOAD,
    OP_FOLD,
    OP_ROTATE,
    OP_TRUNC,
    OP_BASE,
    OP_WRAP,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_REQ,
    C_LOOP,
    C_HOLD
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_HEADING = 4'd5;
  localparam logic [PC_W-1:0] PC_ROTATE  = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT    = 4'd12;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic [29:0] atan_tab(input logic [4:0] idx);
    logic [29:0] t;
    case (idx)
      5'd0:    t = 30'd754974720;
      5'd1:    t = 30'd445687602;
      5'd2:    t = 30'd235489089;
      5'd3:    t = 30'd119537938;
      5'd4:    t = 30'd60000934;
      5'd5:    t = 30'd30029717;
      5'd6:    t = 30'd15018523;
      5'd7:    t = 30'd7509720;
      5'd8:    t = 30'd3754917;
      5'd9:    t = 30'd1877466;
      5'd10:   t = 30'd938734;
      5'd11:   t = 30'd469367;
      5'd12:   t = 30'd234683;
      5'd13:   t = 30'd117342;
      5'd14:   t = 30'd58671;
      5'd15:   t = 30'd29335;
      5'd16:   t = 30'd14668;
      5'd17:   t = 30'd7334;
      5'd18:   t = 30'd3667;
      5'd19:   t = 30'd1833;
      5'd20:   t = 30'd917;
      5'd21:   t = 30'd458;
      5'd22:   t = 30'd229;
      5'd23:   t = 30'd115;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t cw;
    unique case (pc)
      4'd0:    cw = '{OP_NOP,    C_REQ,  4'd1};
      4'd1:    cw = '{OP_NOP,    C_JUMP, PC_HEADING};
      4'd2:    cw = '{OP_SEED,   C_JUMP, PC_EMIT};
      4'd3:    cw = '{OP_TRACK,  C_JUMP, PC_EMIT};
      4'd4:    cw = '{OP_FINISH, C_JUMP, PC_EMIT};
      4'd5:    cw = '{OP_LOAD,   C_NEXT, 4'd0};
      4'd6:    cw = '{OP_FOLD,   C_NEXT, 4'd0};
      4'd7:    cw = '{OP_ROTATE, C_LOOP, PC_ROTATE};
      4'd8:    cw = '{OP_TRUNC,  C_NEXT, 4'd0};
      4'd9:    cw = '{OP_BASE,   C_NEXT, 4'd0};
      4'd10:   cw = '{OP_WRAP,   C_NEXT, 4'd0};
      4'd11:   cw = '{OP_WRAP,   C_NEXT, 4'd0};
      default: cw = '{OP_EMIT,   C_HOLD, 4'd0};
    endcase
    return cw;
  endfunction

endpackage

/* rtl/hard_iron_calibrated_heading_unit.sv */
// ---------------------------------------------------------------------------
// hard_iron_calibrated_heading_unit
// Min/max hard-iron calibration and CORDIC compass heading, run by a
// microcoded sequencer over one shared datapath.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser
//  s_*     | in  | sample_x, sample_y             | req_type
//  m_*     | out | heading_deg, heading_valid,    | -
//          |     | offset_x_out, offset_y_out     |
//
//  Seed, track and finish words go from dispatch via their own step to emit;
//  a heading word runs load, fold, the CORDIC loop on the single shift-add
//  unit, truncate, base and wrap. One word is worked on at a time.
//  rst is synchronous; it clears extremes and offsets to zero.
//  The result register holds while m_tready is low; the next word is
//  taken once the previous one has reached it.
// ---------------------------------------------------------------------------
module hard_iron_calibrated_heading_unit #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_x, sample_y
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // heading_deg, heading_valid, offset_x_out, offset_y_out, pad
);
  import hich_pkg::*;

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int ZW     = ANGLE_FRAC_BITS + WHOLE_W;
  localparam int SH_DN  = (ANGLE_FRAC_BITS < TABLE_FRAC) ? TABLE_FRAC - ANGLE_FRAC_BITS : 0;
  localparam int SH_UP  = (ANGLE_FRAC_BITS > TABLE_FRAC) ? ANGLE_FRAC_BITS - TABLE_FRAC : 0;
  localparam logic [63:0] RND = (SH_DN > 0) ? (64'd1 << (SH_DN - 1)) : 64'd0;

  logic                      busy;
  logic [PC_W-1:0]           pc;
  logic [PC_W-1:0]           pc_next;
  logic [1:0]                req;
  logic signed [15:0]        sx, sy;
  logic signed [15:0]        min_x, max_x, min_y, max_y, offset_x, offset_y;
  logic signed [VEC_W-1:0]   px, py;
  logic signed [ZW-1:0]      z;
  logic [STEP_W-1:0]         step;
  logic signed [WHOLE_W-1:0] whole;
  logic [WHOLE_W-1:0]        bear;

  ctrl_t                     cw;
  logic                      last_step;
  logic                      emit_fire;
  logic signed [DIFF_W-1:0]  num, den;
  logic signed [DIFF_W-1:0]  sum_x, sum_y, adj_x, adj_y;
  logic [63:0]               ang64;
  logic signed [ZW-1:0]      ang;
  logic signed [ZW-1:0]      trunc_sum;

  assign cw        = ucode(pc);
  assign s_tready  = !busy;
  assign last_step = (step == STEP_W'(CORDIC_STEPS - 1));
  assign emit_fire = busy && (cw.op == OP_EMIT) && (!m_tvalid || m_tready);

  assign num = $signed({sx[15], sx}) - $signed({offset_x[15], offset_x});
  assign den = $signed({sy[15], sy}) - $signed({offset_y[15], offset_y});

  // midpoint, truncated toward zero
  assign sum_x = $signed({max_x[15], max_x}) + $signed({min_x[15], min_x});
  assign sum_y = $signed({max_y[15], max_y}) + $signed({min_y[15], min_y});
  assign adj_x = sum_x + $signed({16'd0, sum_x[16]});
  assign adj_y = sum_y + $signed({16'd0, sum_y[16]});

  assign ang64 = ((64'(atan_tab(5'(step))) + RND) >> SH_DN) << SH_UP;
  assign ang   = ZW'(ang64);

  assign trunc_sum = z + $signed({{WHOLE_W{1'b0}}, {ANGLE_FRAC_BITS{z[ZW-1]}}});

  always_comb begin
    unique case (cw.cond)
      C_NEXT:  pc_next = pc + PC_W'(1);
      C_JUMP:  pc_next = cw.target;
      C_REQ:   pc_next = cw.target + PC_W'(req);
      C_LOOP:  pc_next = last_step ? pc + PC_W'(1) : cw.target;
      default: pc_next = pc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pc       <= '0;
      m_tvalid <= 1'b0;
      min_x    <= '0;
      max_x    <= '0;
      min_y    <= '0;
      max_y    <= '0;
      offset_x <= '0;
      offset_y <= '0;
    end else begin
      if (m_tvalid && m_tready && !emit_fire) begin
        m_tvalid <= 1'b0;
      end
      if (!busy) begin
        if (s_tvalid) begin
          busy <= 1'b1;
          pc   <= '0;
          req  <= s_tuser;
          sx   <= s_tdata[15:0];
          sy   <= s_tdata[31:16];
        end
      end else begin
        pc <= pc_next;
        case (cw.op)
          OP_SEED: begin
            min_x <= sx;
            max_x <= sx;
            min_y <= sy;
            max_y <= sy;
          end
          OP_TRACK: begin
            if (sx > max_x) begin
              max_x <= sx;
            end else if (sx < min_x) begin
              min_x <= sx;
            end
            if (sy > max_y) begin
              max_y <= sy;
            end else if (sy < min_y) begin
              min_y <= sy;
            end
          end
          OP_FINISH: begin
            offset_x <= adj_x[16:1];
            offset_y <= adj_y[16:1];
          end
          OP_LOAD: begin
            px <= {{(VEC_W-DIFF_W-GUARD_BITS){den[DIFF_W-1]}}, den, {GUARD_BITS{1'b0}}};
            py <= {{(VEC_W-DIFF_W-GUARD_BITS){num[DIFF_W-1]}}, num, {GUARD_BITS{1'b0}}};
            z  <= '0;
          end
          OP_FOLD: begin
            step <= '0;
            if (px[VEC_W-1]) begin
              px <= -px;
              py <= -py;
              z  <= py[VEC_W-1] ? -$signed(ZW'(180) <<< ANGLE_FRAC_BITS)
                                :  $signed(ZW'(180) <<< ANGLE_FRAC_BITS);
            end
          end
          OP_ROTATE: begin
            step <= step + STEP_W'(1);
            if (py != '0) begin
              if (!py[VEC_W-1]) begin
                px <= px + (py >>> step);
                py <= py - (px >>> step);
                z  <= z + ang;
              end else begin
                px <= px - (py >>> step);
                py <= py + (px >>> step);
                z  <= z - ang;
              end
            end
          end
          OP_TRUNC: begin
            whole <= trunc_sum[ZW-1:ANGLE_FRAC_BITS];
          end
          OP_BASE: begin
            bear <= WHOLE_W'(720) - whole;
          end
          OP_WRAP: begin
            if (bear >= WHOLE_W'(360)) begin
              bear <= bear - WHOLE_W'(360);
            end
          end
          OP_EMIT: begin
            if (emit_fire) begin
              busy     <= 1'b0;
              m_tvalid <= 1'b1;
              m_tdata  <= {6'd0, offset_y, offset_x, (req == REQ_HEADING),
                           (req == REQ_HEADING) ? bear[8:0] : 9'd0};
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:0] < 9'd360))
    else $error("heading out of range");

  a_zero_heading: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[9]) |-> (m_tdata[8:0] == 9'd0))
    else $error("nonzero heading on calibration word");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (busy && pc == '0))
    else $error("sequencer not started");

  a_order_x: assert property (@(posedge clk) disable iff (rst)
    min_x <= max_x)
    else $error("x extremes crossed");

  a_order_y: assert property (@(posedge clk) disable iff (rst)
    min_y <= max_y)
    else $error("y extremes crossed");

endmodule
